@@ hw/rtl/fuzzy_subsequence_filter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Fuzzy subsequence filter assertion macros
// Shorthand for clocked, reset-gated concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_FILTER_UNIT_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_FILTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FSF_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Consequent must hold in the cycle after the antecedent
`define FSF_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

@@ hw/rtl/fsf_pkg.sv @@
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared field widths, bus bit positions and keystroke codes of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsf_pkg;

    // Item field widths
    localparam int KEY_W     = 8;
    localparam int CHAR_W    = 8;
    localparam int PCHAR_W   = 7;
    localparam int HL_W      = 4;
    localparam int LEN_OUT_W = 10;

    // Bus widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Slave-side tdata / tuser layout
    localparam int SD_KEY_LSB   = 0;
    localparam int SD_CHAR_LSB  = 8;
    localparam int SU_OP_BIT    = 0;
    localparam int SU_FIRST_BIT = 1;

    // Master-side tdata layout
    localparam int MD_QUIT_BIT    = 0;
    localparam int MD_HL_LSB      = 1;
    localparam int MD_MATCHED_BIT = 5;
    localparam int MD_LEN_LSB     = 6;

    // Item kinds carried in tuser
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    // Keystroke codes
    localparam logic [KEY_W-1:0] KEY_CTRL_C    = 8'd3;
    localparam logic [KEY_W-1:0] KEY_CTRL_D    = 8'd4;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
    localparam logic [KEY_W-1:0] KEY_CTRL_U    = 8'd21;
    localparam logic [KEY_W-1:0] KEY_CTRL_W    = 8'd23;
    localparam logic [KEY_W-1:0] KEY_SPACE     = 8'd32;
    localparam logic [KEY_W-1:0] KEY_TILDE     = 8'd126;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 8'd127;

endpackage

`default_nettype wire

@@ hw/rtl/fuzzy_subsequence_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Fuzzy subsequence filter unit
// Edits a search pattern from keystrokes and matches each space-separated
// pattern word greedily as a subsequence of streamed candidate characters.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | marks
//  s_      | in  | tdata: key_code, cand_char; tuser: op,first | tlast = last
//  m_      | out | tdata: quit, highlight, matched, length     | tlast = is_end
//
//  Keystroke: accepted in IDLE, where every edit, ^W included, is applied; the result is loaded from FIN.
//  Candidate character: accepted in IDLE, then READ and CMP for each word, then FIN; each word takes
//  one read of the pattern memory's read port and one pass through the shared compare/count.
//  Reset clears length and matchers and sets the word count to one; the pattern memory is not
//  cleared, only entries below the length are ever used.
//  A new item is accepted while a result waits in the output register; the next
//  result holds in its final state until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_filter_unit #(
    parameter int PATTERN_DEPTH = 512,
    parameter int MAX_WORDS     = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // slave side
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [fsf_pkg::S_TDATA_W-1:0]   s_tdata,   // key_code[7:0], cand_char[15:8]
    input  wire logic [fsf_pkg::S_TUSER_W-1:0]   s_tuser,   // op[0], first[1]
    input  wire logic                            s_tlast,
    // master side
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [fsf_pkg::M_TDATA_W-1:0]   m_tdata,   // quit[0], highlight[4:1],
                                                            // matched[5], pattern_length[15:6]
    output      logic                            m_tlast
);

    localparam int AW   = $clog2(PATTERN_DEPTH);
    localparam int LW   = $clog2(PATTERN_DEPTH + 1);
    localparam int TW   = $clog2(MAX_WORDS + 1);
    localparam int WIW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int SP_N = (MAX_WORDS > 1) ? MAX_WORDS - 1 : 1;
    localparam int SPW  = (SP_N > 1) ? $clog2(SP_N) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FIN
    } state_t;

    // Storage
    logic [fsf_pkg::PCHAR_W-1:0] pat_mem [PATTERN_DEPTH];
    logic [fsf_pkg::PCHAR_W-1:0] rdata_reg;
    logic [AW-1:0]               sp_reg [SP_N];       // positions of the pattern spaces
    logic [LW-1:0]               cursor_reg [MAX_WORDS];

    // Control and working registers
    state_t                      state_reg, state_next;
    logic [LW-1:0]               len_reg, len_next;
    logic [TW-1:0]               total_reg, total_next;
    logic [WIW-1:0]              w_reg, w_next;
    logic [LW-1:0]               start_reg, start_next;
    logic [LW-1:0]               end_reg, end_next;
    logic [LW-1:0]               wlen_reg, wlen_next;
    logic                        need_reg, need_next;
    logic [fsf_pkg::CHAR_W-1:0]  c_reg, c_next;
    logic                        last_reg, last_next;
    logic                        quit_reg, quit_next;
    logic [fsf_pkg::HL_W-1:0]    hl_reg, hl_next;
    logic                        all_reg, all_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [fsf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;

    // Combinational helpers
    logic                        in_acc;
    logic                        s_op, s_first;
    logic [fsf_pkg::KEY_W-1:0]   key;
    logic [fsf_pkg::CHAR_W-1:0]  cand;
    logic [SPW-1:0]              sp_rd_idx;
    logic [LW-1:0]               sp_rd;
    logic                        multi_word, last_word, out_free;
    logic [LW-1:0]               word_end, word_len, cur, cur_new;
    logic [AW-1:0]               rd_addr;
    logic                        hit;
    logic                        cur_clr, cur_we, sp_we, mem_we;

    // Input unpacking and handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign s_op     = s_tuser[fsf_pkg::SU_OP_BIT];
    assign s_first  = s_tuser[fsf_pkg::SU_FIRST_BIT];
    assign key      = s_tdata[fsf_pkg::SD_KEY_LSB +: fsf_pkg::KEY_W];
    assign cand     = s_tdata[fsf_pkg::SD_CHAR_LSB +: fsf_pkg::CHAR_W];

    // Space position read port: last space while idle, current word while running
    assign sp_rd_idx  = (state_reg == ST_IDLE) ? SPW'(total_reg - TW'(2)) : SPW'(w_reg);
    assign sp_rd      = LW'(sp_reg[sp_rd_idx]);
    assign multi_word = (total_reg != TW'(1));
    assign last_word  = ((TW'(w_reg) + TW'(1)) == total_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Shared word unit: bounds, cursor check and memory address
    assign word_end = last_word ? len_reg : sp_rd;
    assign word_len = word_end - start_reg;
    assign cur      = cursor_reg[w_reg];
    assign rd_addr  = AW'(start_reg + cur);
    assign hit      = need_reg && ({1'b0, rdata_reg} == c_reg);
    assign cur_new  = cur + LW'(hit);

    // Sequencer and edit logic
    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        total_next    = total_reg;
        w_next        = w_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        wlen_next     = wlen_reg;
        need_next     = need_reg;
        c_next        = c_reg;
        last_next     = last_reg;
        quit_next     = quit_reg;
        hl_next       = hl_reg;
        all_next      = all_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        cur_clr       = 1'b0;
        cur_we        = 1'b0;
        sp_we         = 1'b0;
        mem_we        = 1'b0;

        // output register drains on a completed transaction
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    c_next   = cand;
                    hl_next  = '0;
                    all_next = 1'b1;
                    w_next   = '0;
                    start_next = '0;
                    if (s_op == fsf_pkg::OP_KEY)
                    begin
                        cur_clr    = 1'b1;
                        last_next  = 1'b0;
                        quit_next  = (key == fsf_pkg::KEY_CTRL_C) ||
                                     (key == fsf_pkg::KEY_CTRL_D);
                        state_next = ST_FIN;
                        priority if (quit_next)
                        begin
                            len_next = len_reg;
                        end
                        else if (key == fsf_pkg::KEY_CTRL_U)
                        begin
                            len_next   = '0;
                            total_next = TW'(1);
                        end
                        else if (key == fsf_pkg::KEY_CTRL_W)
                        begin
                            // cut back to the last space, dropping that space
                            if (len_reg != '0)
                            begin
                                len_next   = multi_word ? sp_rd : '0;
                                total_next = multi_word ? total_reg - TW'(1) : TW'(1);
                            end
                        end
                        else if ((key == fsf_pkg::KEY_BACKSPACE) ||
                                 (key == fsf_pkg::KEY_DELETE))
                        begin
                            if (len_reg != '0)
                            begin
                                len_next = len_reg - LW'(1);
                                if (multi_word && (sp_rd == len_reg - LW'(1)))
                                begin
                                    total_next = total_reg - TW'(1);
                                end
                            end
                        end
                        else if ((key >= fsf_pkg::KEY_SPACE) && (key <= fsf_pkg::KEY_TILDE))
                        begin
                            // append unless full, or a space past the word limit
                            if ((len_reg < LW'(PATTERN_DEPTH)) &&
                                !((key == fsf_pkg::KEY_SPACE) &&
                                  (total_reg >= TW'(MAX_WORDS))))
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + LW'(1);
                                if (key == fsf_pkg::KEY_SPACE)
                                begin
                                    sp_we      = 1'b1;
                                    total_next = total_reg + TW'(1);
                                end
                            end
                        end
                        else
                        begin
                            len_next = len_reg;
                        end
                    end
                    else
                    begin
                        cur_clr    = s_first;
                        last_next  = s_tlast;
                        quit_next  = 1'b0;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                need_next  = (cur < word_len);
                wlen_next  = word_len;
                end_next   = word_end;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                cur_we = 1'b1;
                if (hit)
                begin
                    hl_next = fsf_pkg::HL_W'(TW'(w_reg) + TW'(1));
                end
                all_next = all_reg && (cur_new >= wlen_reg);
                if (last_word)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    w_next     = w_reg + WIW'(1);
                    start_next = end_reg + LW'(1);
                    state_next = ST_READ;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_reg;
                    m_tdata_next  = '0;
                    m_tdata_next[fsf_pkg::MD_QUIT_BIT]    = quit_reg;
                    m_tdata_next[fsf_pkg::MD_HL_LSB +: fsf_pkg::HL_W] = hl_reg;
                    m_tdata_next[fsf_pkg::MD_MATCHED_BIT] = last_reg && all_reg;
                    m_tdata_next[fsf_pkg::MD_LEN_LSB +: fsf_pkg::LEN_OUT_W] =
                        fsf_pkg::LEN_OUT_W'(len_reg);
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            total_reg    <= TW'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        wlen_reg    <= wlen_next;
        need_reg    <= need_next;
        c_reg       <= c_next;
        last_reg    <= last_next;
        quit_reg    <= quit_next;
        hl_reg      <= hl_next;
        all_reg     <= all_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Word matcher cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WORDS; i++)
            begin
                cursor_reg[i] <= '0;
            end
        end
        else if (cur_clr)
        begin
            for (int i = 0; i < MAX_WORDS; i++)
            begin
                cursor_reg[i] <= '0;
            end
        end
        else if (cur_we)
        begin
            cursor_reg[w_reg] <= cur_new;
        end
    end

    // Space positions, one per word boundary
    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_reg[SPW'(total_reg - TW'(1))] <= AW'(len_reg);
        end
    end

    // Pattern memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[AW'(len_reg)] <= key[fsf_pkg::PCHAR_W-1:0];
        end
        rdata_reg <= pat_mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fsf_checker.sv @@
// ----------------------------------------------------------------------------
// fsf_checker
// Port-level checks on the fuzzy subsequence filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fuzzy_subsequence_filter_unit_defines.svh"

module fsf_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [fsf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            m_tlast
);

    // Stalled result holds
    `FSF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // One item at a time: ready drops right after a transaction
    `FSF_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    // Quit results carry no candidate information
    `FSF_ASSERT_SAME(a_quit_clean, clk, rst_n, m_tvalid && m_tdata[fsf_pkg::MD_QUIT_BIT], !m_tlast && (m_tdata[fsf_pkg::MD_HL_LSB +: fsf_pkg::HL_W] == '0) && !m_tdata[fsf_pkg::MD_MATCHED_BIT], "quit result with match fields set")

    // Match is only reported on the final candidate character
    `FSF_ASSERT_SAME(a_match_end, clk, rst_n, m_tvalid && m_tdata[fsf_pkg::MD_MATCHED_BIT], m_tlast, "matched without end of candidate")

endmodule

bind fuzzy_subsequence_filter_unit fsf_checker u_fsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
